### design/csp_pkg.sv
`default_nettype none
package csp_pkg;

  localparam int NUM_COLORS   = 148;
  // The longest table name has this many characters.
  localparam int TABLE_NAME_LEN = 20;
  localparam int MAX_NAME_LEN_DEF = 20;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [1:0] SRC_HEX     = 2'd0;
  localparam logic [1:0] SRC_NAMED   = 2'd1;
  localparam logic [1:0] SRC_UNKNOWN = 2'd2;

  localparam logic [7:0]  CHAR_TERM    = 8'h00;
  localparam logic [7:0]  CHAR_HASH    = 8'h23;
  localparam logic [31:0] OPAQUE_BLACK = 32'h0000_00FF;
  localparam logic [31:0] ALPHA_OPAQUE = 32'h0000_00FF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEX,
    PH_NAME
  } csp_phase_t;

  typedef struct packed {
    logic       term;
    logic       hash;
    logic [3:0] nib;
    logic [7:0] lc;
  } csp_item_t;

  typedef logic [8*TABLE_NAME_LEN-1:0] csp_name_t;

  // Names are right-justified: the last character sits in the low byte.
  localparam csp_name_t COLOR_NAMES [NUM_COLORS] = '{
    "maroon","darkred","brown","firebrick","crimson","red","tomato","coral",
    "indianred","lightcoral","darksalmon","salmon","lightsalmon","orangered",
    "darkorange","orange","gold","darkgoldenrod","goldenrod","palegoldenrod",
    "darkkhaki","khaki","olive","yellow","yellowgreen","darkolivegreen",
    "olivedrab","lawngreen","chartreuse","greenyellow","darkgreen","green",
    "forestgreen","lime","limegreen","lightgreen","palegreen","darkseagreen",
    "mediumspringgreen","springgreen","seagreen","mediumaquamarine",
    "mediumseagreen","lightseagreen","darkslategray","darkslategrey","teal",
    "darkcyan","aqua","cyan","lightcyan","darkturquoise","turquoise",
    "mediumturquoise","paleturquoise","aquamarine","powderblue","cadetblue",
    "steelblue","cornflowerblue","deepskyblue","dodgerblue","lightblue",
    "skyblue","lightskyblue","midnightblue","navy","darkblue","mediumblue",
    "blue","royalblue","blueviolet","indigo","darkslateblue","slateblue",
    "mediumslateblue","mediumpurple","darkmagenta","darkviolet","darkorchid",
    "mediumorchid","purple","thistle","plum","violet","magenta","fuchsia",
    "orchid","mediumvioletred","palevioletred","deeppink","hotpink",
    "lightpink","pink","antiquewhite","beige","bisque","blanchedalmond",
    "wheat","cornsilk","lemonchiffon","lightgoldenrodyellow","lightyellow",
    "saddlebrown","sienna","chocolate","peru","sandybrown","burlywood","tan",
    "rosybrown","moccasin","navajowhite","peachpuff","mistyrose",
    "lavenderblush","linen","oldlace","papayawhip","seashell","mintcream",
    "slategray","slategrey","lightslategray","lightslategrey",
    "lightsteelblue","lavender","floralwhite","aliceblue","ghostwhite",
    "honeydew","ivory","azure","snow","black","dimgray","dimgrey","gray",
    "grey","darkgray","darkgrey","silver","lightgray","lightgrey",
    "gainsboro","whitesmoke","white","transparent"
  };

  localparam logic [31:0] COLOR_RGBA [NUM_COLORS] = '{
    32'h800000FF,32'h8B0000FF,32'hA52A2AFF,32'hB22222FF,32'hDC143CFF,32'hFF0000FF,
    32'hFF6347FF,32'hFF7F50FF,32'hCD5C5CFF,32'hF08080FF,32'hE9967AFF,32'hFA8072FF,
    32'hFFA07AFF,32'hFF4500FF,32'hFF8C00FF,32'hFFA500FF,32'hFFD700FF,32'hB8860BFF,
    32'hDAA520FF,32'hEEE8AAFF,32'hBDB76BFF,32'hF0E68CFF,32'h808000FF,32'hFFFF00FF,
    32'h9ACD32FF,32'h556B2FFF,32'h6B8E23FF,32'h7CFC00FF,32'h7FFF00FF,32'hADFF2FFF,
    32'h006400FF,32'h008000FF,32'h228B22FF,32'h00FF00FF,32'h32CD32FF,32'h90EE90FF,
    32'h98FB98FF,32'h8FBC8FFF,32'h00FA9AFF,32'h00FF7FFF,32'h2E8B57FF,32'h66CDAAFF,
    32'h3CB371FF,32'h20B2AAFF,32'h2F4F4FFF,32'h2F4F4FFF,32'h008080FF,32'h008B8BFF,
    32'h00FFFFFF,32'h00FFFFFF,32'hE0FFFFFF,32'h00CED1FF,32'h40E0D0FF,32'h48D1CCFF,
    32'hAFEEEEFF,32'h7FFFD4FF,32'hB0E0E6FF,32'h5F9EA0FF,32'h4682B4FF,32'h6495EDFF,
    32'h00BFFFFF,32'h1E90FFFF,32'hADD8E6FF,32'h87CEEBFF,32'h87CEFAFF,32'h191970FF,
    32'h000080FF,32'h00008BFF,32'h0000CDFF,32'h0000FFFF,32'h4169E1FF,32'h8A2BE2FF,
    32'h4B0082FF,32'h483D8BFF,32'h6A5ACDFF,32'h7B68EEFF,32'h9370DBFF,32'h8B008BFF,
    32'h9400D3FF,32'h9932CCFF,32'hBA55D3FF,32'h800080FF,32'hD8BFD8FF,32'hDDA0DDFF,
    32'hEE82EEFF,32'hFF00FFFF,32'hFF00FFFF,32'hDA70D6FF,32'hC71585FF,32'hDB7093FF,
    32'hFF1493FF,32'hFF69B4FF,32'hFFB6C1FF,32'hFFC0CBFF,32'hFAEBD7FF,32'hF5F5DCFF,
    32'hFFE4C4FF,32'hFFEBCDFF,32'hF5DEB3FF,32'hFFF8DCFF,32'hFFFACDFF,32'hFAFAD2FF,
    32'hFFFFE0FF,32'h8B4513FF,32'hA0522DFF,32'hD2691EFF,32'hCD853FFF,32'hF4A460FF,
    32'hDEB887FF,32'hD2B48CFF,32'hBC8F8FFF,32'hFFE4B5FF,32'hFFDEADFF,32'hFFDAB9FF,
    32'hFFE4E1FF,32'hFFF0F5FF,32'hFAF0E6FF,32'hFDF5E6FF,32'hFFEFD5FF,32'hFFF5EEFF,
    32'hF5FFFAFF,32'h708090FF,32'h708090FF,32'h778899FF,32'h778899FF,32'hB0C4DEFF,
    32'hE6E6FAFF,32'hFFFAF0FF,32'hF0F8FFFF,32'hF8F8FFFF,32'hF0FFF0FF,32'hFFFFF0FF,
    32'hF0FFFFFF,32'hFFFAFAFF,32'h000000FF,32'h696969FF,32'h696969FF,32'h808080FF,
    32'h808080FF,32'hA9A9A9FF,32'hA9A9A9FF,32'hC0C0C0FF,32'hD3D3D3FF,32'hD3D3D3FF,
    32'hDCDCDCFF,32'hF5F5F5FF,32'hFFFFFFFF,32'h00000000
  };

endpackage
`default_nettype wire

### design/csp_front.sv
`default_nettype none
module csp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,
  output logic                   item_valid,
  input  wire logic              item_ready,
  output csp_pkg::csp_item_t     item
);
  import csp_pkg::*;

  logic      valid_r;
  csp_item_t item_r;
  csp_item_t item_nxt;

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.term = (in_tdata == CHAR_TERM);
    item_nxt.hash = (in_tdata == CHAR_HASH);
    if (in_tdata >= "0" && in_tdata <= "9") begin
      item_nxt.nib = in_tdata[3:0];
    end else if ((in_tdata >= "A" && in_tdata <= "F") ||
                 (in_tdata >= "a" && in_tdata <= "f")) begin
      // Both letter ranges have 1..6 in the low nibble.
      item_nxt.nib = in_tdata[3:0] + 4'd9;
    end else begin
      item_nxt.nib = 4'd0;
    end
    if (in_tdata >= "A" && in_tdata <= "Z") begin
      item_nxt.lc = in_tdata | 8'h20;
    end else begin
      item_nxt.lc = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

### design/csp_queue.sv
`default_nettype none
module csp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire csp_pkg::csp_item_t wr_item,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output csp_pkg::csp_item_t     rd_item
);
  import csp_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  csp_item_t       mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign wr_ready = (count_r != CntW'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

### design/csp_back.sv
`default_nettype none
module csp_back #(
  parameter int MAX_NAME_LEN = csp_pkg::MAX_NAME_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire csp_pkg::csp_item_t item,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [31:0]            out_tdata,
  output logic [1:0]             out_tuser
);
  import csp_pkg::*;

  localparam int NameW = 8 * MAX_NAME_LEN;

  csp_phase_t        phase_r, phase_nxt;
  logic [31:0]       hex_accum_r, hex_accum_nxt;
  logic [3:0]        hex_count_r, hex_count_nxt;
  logic [NameW-1:0]  name_r, name_nxt;
  logic              ovf_r, ovf_nxt;

  logic              pop;
  logic              pop_term;
  logic              s1_ready;
  logic              s2_ready;

  logic              s1_valid_r;
  logic              s1_hex_r;
  logic [31:0]       s1_hex_rgba_r;
  logic [NUM_COLORS-1:0] s1_match_r;
  logic [NUM_COLORS-1:0] match_c;

  logic              out_valid_r;
  logic [31:0]       out_rgba_r;
  logic [1:0]        out_kind_r;
  logic [31:0]       sel_rgba;

  assign s2_ready   = !out_valid_r || out_tready;
  assign s1_ready   = !s1_valid_r || s2_ready;
  assign item_ready = !item.term || s1_ready;
  assign pop        = item_valid && item_ready;
  assign pop_term   = pop && item.term;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rgba_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      if (item.term) begin
        phase_nxt = PH_IDLE;
      end else begin
        case (phase_r)
          PH_IDLE: phase_nxt = item.hash ? PH_HEX : PH_NAME;
          PH_HEX:  phase_nxt = PH_HEX;
          PH_NAME: phase_nxt = PH_NAME;
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    hex_accum_nxt = hex_accum_r;
    hex_count_nxt = hex_count_r;
    name_nxt      = name_r;
    ovf_nxt       = ovf_r;
    if (pop_term) begin
      hex_accum_nxt = '0;
      hex_count_nxt = '0;
      name_nxt      = '0;
      ovf_nxt       = 1'b0;
    end else if (pop) begin
      if (phase_r == PH_HEX) begin
        if (hex_count_r < 4'd8) begin
          hex_accum_nxt = hex_accum_r | (32'(item.nib) << {~hex_count_r[2:0], 2'b00});
        end
        if (hex_count_r < 4'd9) begin
          hex_count_nxt = hex_count_r + 4'd1;
        end
      end else if (phase_r == PH_NAME || !item.hash) begin
        // A character pushed past the buffer top makes the name unmatchable.
        name_nxt = {name_r[NameW-9:0], item.lc};
        ovf_nxt  = ovf_r || (name_r[NameW-1 -: 8] != 8'd0);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COLORS; k++) begin
      match_c[k] = !ovf_r && (name_r == NameW'(COLOR_NAMES[k]));
    end
  end

  always_comb begin
    sel_rgba = '0;
    for (int k = 0; k < NUM_COLORS; k++) begin
      sel_rgba = sel_rgba | (s1_match_r[k] ? COLOR_RGBA[k] : 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hex_accum_r <= '0;
      hex_count_r <= '0;
      name_r      <= '0;
      ovf_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hex_accum_r <= hex_accum_nxt;
      hex_count_r <= hex_count_nxt;
      name_r      <= name_nxt;
      ovf_r       <= ovf_nxt;
      if (pop_term) begin
        s1_valid_r <= 1'b1;
      end else if (s2_ready) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && s2_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_term) begin
      s1_hex_r      <= (phase_r == PH_HEX);
      s1_hex_rgba_r <= hex_accum_r | ((hex_count_r <= 4'd6) ? ALPHA_OPAQUE : 32'd0);
      s1_match_r    <= match_c;
    end
    if (s1_valid_r && s2_ready) begin
      if (s1_hex_r) begin
        out_rgba_r <= s1_hex_rgba_r;
        out_kind_r <= SRC_HEX;
      end else if (|s1_match_r) begin
        out_rgba_r <= sel_rgba;
        out_kind_r <= SRC_NAMED;
      end else begin
        out_rgba_r <= OPAQUE_BLACK;
        out_kind_r <= SRC_UNKNOWN;
      end
    end
  end

endmodule
`default_nettype wire

### design/color_string_parser.sv
// Channel  Direction  tdata                      tuser
// in_      input      [7:0] char_code            -
// out_     output     [31:0] rgba                [1:0] source_kind
//
// One character word per cycle is taken in while in_tready is high. A terminator
// passes the character stage, the queue and both result stages before out_tvalid rises.
// The character stage, a two-word queue and a two-stage result pipe
// (table compare, then select) decouple input and output stalls.
// Reset (rst_n low, synchronous) empties every stage and clears the parse state.
`default_nettype none
module color_string_parser #(
  parameter int MAX_NAME_LEN = csp_pkg::MAX_NAME_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] rgba
  output logic [1:0]       out_tuser   // [1:0] source_kind
);
  import csp_pkg::*;

  logic      f_valid, f_ready;
  csp_item_t f_item;
  logic      q_valid, q_ready;
  csp_item_t q_item;

  csp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  csp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  csp_back #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef NO_ASSERTIONS
  a_unknown_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == SRC_UNKNOWN |-> out_tdata == OPAQUE_BLACK)
    else $error("unknown name did not give opaque black");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == SRC_HEX || out_tuser == SRC_NAMED ||
                   out_tuser == SRC_UNKNOWN)
    else $error("reserved source kind on output");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire
